FILE: hw/rtl/error_state_correction_apply_assert.svh
// Assertion macros used by the back stage of the correction block.
`ifndef ERROR_STATE_CORRECTION_APPLY_ASSERT_SVH
`define ERROR_STATE_CORRECTION_APPLY_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define ESCA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check a consequent in the cycle after its antecedent.
`define ESCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/esca_pkg.sv
// Types, constants and helpers shared by the correction block.
`timescale 1ns / 1ps
package esca_pkg;

    localparam int WORD_BITS   = 32;
    localparam int FRAC_BITS   = 24;
    localparam int PROD_BITS   = 2 * WORD_BITS;
    localparam int DVD_BITS    = WORD_BITS - 1 + FRAC_BITS;
    localparam int TWO_SHIFT   = FRAC_BITS - 1;
    localparam int ZERO_SHIFT  = FRAC_BITS - 2;
    localparam int NORM_HI     = 30;
    localparam int NORM_LO     = 29;
    localparam int NUM_PROD    = 12;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] MODE_QUAT = 2'd0;
    localparam logic [1:0] MODE_VEC  = 2'd1;
    localparam logic [1:0] MODE_STAT = 2'd2;

    localparam logic signed [PROD_BITS-1:0] WMAX64 =
        (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
    localparam logic signed [PROD_BITS-1:0] WMIN64 = -WMAX64 - 64'sd1;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [1:0] lane_t;

    typedef struct packed {
        logic [1:0]  mode;
        word_t       state_x;
        word_t       state_y;
        word_t       state_z;
        word_t       state_w;
        word_t       delta_x;
        word_t       delta_y;
        word_t       delta_z;
        logic [15:0] status_in;
        logic [1:0]  update_bits;
        logic        last_segment;
    } esca_in_t;

    typedef struct packed {
        word_t       out_x;
        word_t       out_y;
        word_t       out_z;
        word_t       out_w;
        logic [15:0] status_out;
        logic        last_out;
    } esca_out_t;

    // Classified item: quaternion operands, or a result already final.
    typedef struct packed {
        logic      is_quat;
        word_t     qx;
        word_t     qy;
        word_t     qz;
        word_t     qw;
        word_t     gx;
        word_t     gy;
        word_t     gz;
        esca_out_t res;
    } esca_entry_t;

    // Product schedule: quaternion lane, gibbs lane, target sum, negate.
    localparam lane_t PROD_QSEL [NUM_PROD] = '{
        2'd3, 2'd2, 2'd1, 2'd2, 2'd3, 2'd0,
        2'd1, 2'd0, 2'd3, 2'd0, 2'd1, 2'd2};
    localparam lane_t PROD_GSEL [NUM_PROD] = '{
        2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
        2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};
    localparam lane_t PROD_DST [NUM_PROD] = '{
        2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1,
        2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3};
    localparam logic PROD_NEG [NUM_PROD] = '{
        1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
        1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};

    // Clamp a wide signed value to the word range.
    function automatic word_t sat_word(input logic signed [PROD_BITS-1:0] v);
        word_t r;
        if (v > WMAX64)
            r = WMAX64[WORD_BITS-1:0];
        else if (v < WMIN64)
            r = WMIN64[WORD_BITS-1:0];
        else
            r = v[WORD_BITS-1:0];
        return r;
    endfunction

endpackage

FILE: hw/rtl/esca_front.sv
// Front stage: accept a transaction, classify it and finish the cheap modes.
`timescale 1ns / 1ps
module esca_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  esca_pkg::esca_in_t    item,
    output logic                  entry_valid,
    input  logic                  entry_ready,
    output esca_pkg::esca_entry_t entry
);
    import esca_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    esca_entry_t entry_reg;
    esca_entry_t entry_next;
    logic        take;

    assign full        = valid_reg && !entry_ready;
    assign take        = push && !full;
    assign entry_valid = valid_reg;
    assign entry       = entry_reg;

    // Classify by mode; vector add and status merge finish here
    always_comb
    begin
        entry_next = '0;
        entry_next.qx = item.state_x;
        entry_next.qy = item.state_y;
        entry_next.qz = item.state_z;
        entry_next.qw = item.state_w;
        entry_next.gx = item.delta_x;
        entry_next.gy = item.delta_y;
        entry_next.gz = item.delta_z;
        entry_next.res.last_out = item.last_segment;
        case (item.mode)
            MODE_QUAT:
            begin
                entry_next.is_quat = 1'b1;
            end
            MODE_VEC:
            begin
                entry_next.res.out_x = sat_word(PROD_BITS'(item.state_x)
                                                + PROD_BITS'(item.delta_x));
                entry_next.res.out_y = sat_word(PROD_BITS'(item.state_y)
                                                + PROD_BITS'(item.delta_y));
                entry_next.res.out_z = sat_word(PROD_BITS'(item.state_z)
                                                + PROD_BITS'(item.delta_z));
            end
            MODE_STAT:
            begin
                entry_next.res.status_out = {item.status_in[15:2], item.update_bits};
            end
            default:
            begin
                entry_next.is_quat = 1'b0;
            end
        endcase
    end

    // Hold the item until the queue takes it
    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (entry_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            entry_reg <= entry_next;
    end

endmodule

FILE: hw/rtl/esca_queue.sv
// Short queue between the front and back stages.
`timescale 1ns / 1ps
module esca_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_valid,
    output logic                  wr_ready,
    input  esca_pkg::esca_entry_t wr_data,
    output logic                  rd_valid,
    input  logic                  rd_en,
    output esca_pkg::esca_entry_t rd_data
);
    import esca_pkg::*;

    esca_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign wr_ready = count_reg != QCNT_BITS'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_en && rd_valid;
    assign rd_data  = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (!do_wr && do_rd)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

FILE: hw/rtl/esca_back.sv
// Back stage: quaternion correction sequencer and result register.
`timescale 1ns / 1ps
`include "error_state_correction_apply_assert.svh"
module esca_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  esca_pkg::esca_entry_t q_data,
    output logic                  empty,
    input  logic                  pop,
    output esca_pkg::esca_out_t   result
);
    import esca_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_FLIP = 3'd2;
    localparam logic [2:0] S_NORM = 3'd3;
    localparam logic [2:0] S_SQ   = 3'd4;
    localparam logic [2:0] S_SQRT = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    localparam int CNT_BITS = 6;
    localparam logic [CNT_BITS-1:0] MUL_END  = CNT_BITS'(NUM_PROD);
    localparam logic [CNT_BITS-1:0] SQ_END   = CNT_BITS'(4);
    localparam logic [CNT_BITS-1:0] SQRT_END = CNT_BITS'(WORD_BITS - 1);
    localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(DVD_BITS - 1);
    localparam int R4 = NORM_HI + 3;
    localparam int L4 = NORM_LO - 3;

    logic [2:0]                  state_reg, state_next;
    logic [CNT_BITS-1:0]         cnt_reg, cnt_next;
    word_t                       qv_reg [4];
    word_t                       qv_next [4];
    word_t                       gv_reg [3];
    word_t                       gv_next [3];
    logic                        last_reg, last_next;
    logic signed [PROD_BITS-1:0] v_reg [4];
    logic signed [PROD_BITS-1:0] v_next [4];
    logic signed [PROD_BITS-1:0] prod_reg, prod_next;
    logic                        prod_vld_reg, prod_vld_next;
    logic                        prod_sq_reg, prod_sq_next;
    logic                        prod_neg_reg, prod_neg_next;
    lane_t                       prod_dst_reg, prod_dst_next;
    logic [PROD_BITS-1:0]        mor_reg, mor_next;
    logic [PROD_BITS-1:0]        ss_reg, ss_next;
    logic [PROD_BITS-1:0]        root_reg, root_next;
    logic [PROD_BITS-1:0]        bit_reg, bit_next;
    logic [WORD_BITS-1:0]        mag_reg, mag_next;
    logic [DVD_BITS-1:0]         dvd_reg [4];
    logic [DVD_BITS-1:0]         dvd_next [4];
    logic [WORD_BITS-1:0]        rem_reg [4];
    logic [WORD_BITS-1:0]        rem_next [4];
    logic                        neg_reg [4];
    logic                        neg_next [4];
    word_t                       r_reg [4];
    word_t                       r_next [4];
    logic                        out_valid_reg, out_valid_next;
    esca_out_t                   out_reg, out_next;

    logic                        out_free;
    logic [3:0]                  mul_idx;
    word_t                       mul_a, mul_b;
    logic signed [PROD_BITS-1:0] prod_q;
    logic signed [PROD_BITS-1:0] absv [4];
    logic [PROD_BITS-1:0]        trial;
    logic [WORD_BITS-1:0]        mag_w;
    logic [WORD_BITS:0]          rem_sh [4];
    logic signed [PROD_BITS-1:0] quo [4];

    assign out_free = !out_valid_reg || pop;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;
    assign mul_idx  = (cnt_reg < MUL_END) ? cnt_reg[3:0] : 4'd0;
    assign prod_q   = prod_reg >>> 2;
    assign trial    = root_reg + bit_reg;

    // Select operands of the shared multiplier
    always_comb
    begin
        mul_a = qv_reg[PROD_QSEL[mul_idx]];
        mul_b = gv_reg[PROD_GSEL[mul_idx]];
        if (state_reg == S_SQ)
        begin
            mul_a = v_reg[cnt_reg[1:0]][WORD_BITS-1:0];
            mul_b = v_reg[cnt_reg[1:0]][WORD_BITS-1:0];
        end
    end

    // Magnitudes of the four sums
    always_comb
    begin
        for (int i = 0; i < 4; i++)
            absv[i] = (v_reg[i] < 0) ? -v_reg[i] : v_reg[i];
    end

    // Sequence the correction of one quaternion, or pass a finished result on
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        qv_next       = qv_reg;
        gv_next       = gv_reg;
        last_next     = last_reg;
        v_next        = v_reg;
        prod_next     = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
        prod_vld_next = 1'b0;
        prod_sq_next  = 1'b0;
        prod_neg_next = PROD_NEG[mul_idx];
        prod_dst_next = PROD_DST[mul_idx];
        mor_next      = mor_reg;
        ss_next       = ss_reg;
        root_next     = root_reg;
        bit_next      = bit_reg;
        mag_next      = mag_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        neg_next      = neg_reg;
        r_next        = r_reg;
        out_next      = out_reg;
        out_valid_next = out_valid_reg && !pop;
        q_pop         = 1'b0;
        mag_w         = '0;
        for (int i = 0; i < 4; i++)
        begin
            rem_sh[i] = {rem_reg[i], dvd_reg[i][DVD_BITS-1]};
            quo[i]    = '0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    if (q_data.is_quat)
                    begin
                        qv_next[0] = q_data.qx;
                        qv_next[1] = q_data.qy;
                        qv_next[2] = q_data.qz;
                        qv_next[3] = q_data.qw;
                        gv_next[0] = q_data.gx;
                        gv_next[1] = q_data.gy;
                        gv_next[2] = q_data.gz;
                        last_next  = q_data.res.last_out;
                        v_next[0]  = PROD_BITS'(q_data.qx) <<< TWO_SHIFT;
                        v_next[1]  = PROD_BITS'(q_data.qy) <<< TWO_SHIFT;
                        v_next[2]  = PROD_BITS'(q_data.qz) <<< TWO_SHIFT;
                        v_next[3]  = PROD_BITS'(q_data.qw) <<< TWO_SHIFT;
                        cnt_next   = '0;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        out_next       = q_data.res;
                        out_valid_next = 1'b1;
                    end
                end
            end
            S_MUL:
            begin
                // issue one product a cycle, fold in the one before
                if (prod_vld_reg)
                    v_next[prod_dst_reg] = prod_neg_reg ? v_reg[prod_dst_reg] - prod_q
                                                        : v_reg[prod_dst_reg] + prod_q;
                if (cnt_reg < MUL_END)
                begin
                    prod_vld_next = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = S_FLIP;
                end
            end
            S_FLIP:
            begin
                mor_next = absv[0] | absv[1] | absv[2] | absv[3];
                if (v_reg[3] == 0)
                begin
                    // no normalization: convert straight back to the word format
                    for (int i = 0; i < 4; i++)
                        r_next[i] = sat_word(v_reg[i] >>> ZERO_SHIFT);
                    state_next = S_DONE;
                end
                else
                begin
                    if (v_reg[3] < 0)
                        for (int i = 0; i < 4; i++)
                            v_next[i] = -v_reg[i];
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                // bring the largest magnitude into the normalized window
                if ((mor_reg >> R4) != '0)
                begin
                    for (int i = 0; i < 4; i++)
                        v_next[i] = v_reg[i] >>> 4;
                    mor_next = mor_reg >> 4;
                end
                else if ((mor_reg >> NORM_HI) != '0)
                begin
                    for (int i = 0; i < 4; i++)
                        v_next[i] = v_reg[i] >>> 1;
                    mor_next = mor_reg >> 1;
                end
                else if ((mor_reg >> L4) == '0)
                begin
                    for (int i = 0; i < 4; i++)
                        v_next[i] = v_reg[i] <<< 4;
                    mor_next = mor_reg << 4;
                end
                else if ((mor_reg >> NORM_LO) == '0)
                begin
                    for (int i = 0; i < 4; i++)
                        v_next[i] = v_reg[i] <<< 1;
                    mor_next = mor_reg << 1;
                end
                else
                begin
                    cnt_next   = '0;
                    ss_next    = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                // sum of squares through the shared multiplier
                if (prod_vld_reg && prod_sq_reg)
                    ss_next = ss_reg + prod_reg;
                if (cnt_reg < SQ_END)
                begin
                    prod_vld_next = 1'b1;
                    prod_sq_next  = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                end
                else
                begin
                    root_next  = '0;
                    bit_next   = PROD_BITS'(1) << (PROD_BITS - 2);
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                // one result bit of the integer square root a cycle
                if (ss_reg >= trial)
                begin
                    ss_next   = ss_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SQRT_END)
                begin
                    mag_w    = root_next[WORD_BITS-1:0];
                    mag_next = (mag_w == '0) ? WORD_BITS'(1) : mag_w;
                    for (int i = 0; i < 4; i++)
                    begin
                        dvd_next[i] = DVD_BITS'(absv[i] << FRAC_BITS);
                        rem_next[i] = '0;
                        neg_next[i] = v_reg[i] < 0;
                    end
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // restoring division, four lanes, one quotient bit a cycle
                for (int i = 0; i < 4; i++)
                begin
                    if (rem_sh[i] >= {1'b0, mag_reg})
                    begin
                        rem_next[i] = WORD_BITS'(rem_sh[i] - {1'b0, mag_reg});
                        dvd_next[i] = {dvd_reg[i][DVD_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[i] = rem_sh[i][WORD_BITS-1:0];
                        dvd_next[i] = {dvd_reg[i][DVD_BITS-2:0], 1'b0};
                    end
                    quo[i] = PROD_BITS'(dvd_next[i]);
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    for (int i = 0; i < 4; i++)
                        r_next[i] = sat_word(neg_reg[i] ? -quo[i] : quo[i]);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next.out_x      = r_reg[0];
                    out_next.out_y      = r_reg[1];
                    out_next.out_z      = r_reg[2];
                    out_next.out_w      = r_reg[3];
                    out_next.status_out = '0;
                    out_next.last_out   = last_reg;
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            prod_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            prod_vld_reg  <= prod_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        qv_reg       <= qv_next;
        gv_reg       <= gv_next;
        last_reg     <= last_next;
        v_reg        <= v_next;
        prod_reg     <= prod_next;
        prod_sq_reg  <= prod_sq_next;
        prod_neg_reg <= prod_neg_next;
        prod_dst_reg <= prod_dst_next;
        mor_reg      <= mor_next;
        ss_reg       <= ss_next;
        root_reg     <= root_next;
        bit_reg      <= bit_next;
        mag_reg      <= mag_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        r_reg        <= r_next;
        out_reg      <= out_next;
    end

    `ESCA_ASSERT_IMPL(a_pop_has_entry, clk, rst_n, q_pop, q_valid)
    `ESCA_ASSERT_IMPL(a_no_pop_busy, clk, rst_n, state_reg != S_IDLE, !q_pop)
    `ESCA_ASSERT_NEXT(a_div_ends, clk, rst_n, (state_reg == S_DIV) && (cnt_reg == DIV_LAST), state_reg == S_DONE)
    `ESCA_ASSERT_NEXT(a_done_loads, clk, rst_n, (state_reg == S_DONE) && !out_valid_reg, out_valid_reg)

endmodule

FILE: hw/rtl/error_state_correction_apply.sv
// Path: vector add, status merge and unused modes are finished in the front stage and pass
// the front register, queue and result register; a quaternion then runs the multiply,
// flip, normalize and squaring steps, the 32-step square root and the 55-step restoring
// divider, or only the multiply and flip steps when the corrected w is zero.
// Throughput: one cheap item per cycle if results are popped; none during a quaternion.
// Reset: rst_n clears the queue, the sequencer and the result valid; no clearing pass.
`timescale 1ns / 1ps
module error_state_correction_apply (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  esca_pkg::esca_in_t  item,
    output logic                empty,
    input  logic                pop,
    output esca_pkg::esca_out_t result
);
    import esca_pkg::*;

    esca_entry_t front_entry;
    logic        front_valid;
    logic        front_ready;
    esca_entry_t queue_entry;
    logic        queue_valid;
    logic        queue_pop;

    // Accept and classify
    esca_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .item        (item),
        .entry_valid (front_valid),
        .entry_ready (front_ready),
        .entry       (front_entry)
    );

    // Decouple the two stages
    esca_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_data  (front_entry),
        .rd_valid (queue_valid),
        .rd_en    (queue_pop),
        .rd_data  (queue_entry)
    );

    // Carry out the correction
    esca_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (queue_valid),
        .q_pop   (queue_pop),
        .q_data  (queue_entry),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
